[rtl/core/kufb_pkg.sv]
// ----------------------------------------------------------------------------
// kufb_pkg: shared types and constants for the spanning-tree builder
// Field widths, default sizes and the sequencer state encoding.
// ----------------------------------------------------------------------------
package kufb_pkg;

  // Fixed field widths of the stream payloads.
  localparam int unsigned NODE_W   = 10;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned TOTAL_W  = 26;

  // Packed stream widths, padded to whole bytes.
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 40;

  // Width of the generation tag kept with each forest entry.
  localparam int unsigned GEN_W = 4;

  // Defaults.
  localparam int unsigned MAX_NODES_DEF  = 1024;
  localparam int unsigned NODE_COUNT_RST = 1023;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_BEGIN,
    ST_FIND_RD,
    ST_FIND_CHK,
    ST_COMP_RD,
    ST_COMP_WR,
    ST_LINK,
    ST_RESULT
  } kufb_state_e;

endpackage

[rtl/core/kufb_ram.sv]
// ----------------------------------------------------------------------------
// kufb_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module kufb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/kruskal_union_find_tree_builder.sv]
// ----------------------------------------------------------------------------
// kruskal_union_find_tree_builder: union-find spanning-tree accumulator
// Takes edges in weight order, finds both endpoint roots with path
// compression, links separate trees and keeps the running tree weight.
// ----------------------------------------------------------------------------
//
//   channel   direction  payload                                   width
//   s_axis    in         start, end, weight (tdata); first (tuser)  40 + 1
//   m_axis    out        joined, tree_weight, edges_taken, complete 40
//   cfg       in         node_count                                 10
//
// From accept to result an edge walks both endpoint paths (one RAM read per walk
// step) and compresses them; an ignored edge goes straight to its result.
// After reset and on every sixteenth first edge, a clearing pass rewrites all
// min(MAX_NODES, 1024) entries of the forest RAM and no beat is taken.
// A result waits in the output register until taken; the next edge is accepted
// only after its result has been loaded.
//
module kruskal_union_find_tree_builder
  import kufb_pkg::*;
#(
  parameter int unsigned MAX_NODES = MAX_NODES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Edge input: [9:0] edge_start, [19:10] edge_end, [35:20] edge_weight.
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // Edge flag: [0] first_edge.
  input  logic [0:0]            s_axis_tuser_i,
  // Result: [0] joined, [26:1] tree_weight, [36:27] edges_taken, [37] complete.
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // Register write: node_count.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [NODE_W-1:0]     cfg_data_i
);

  // Only node indices that fit the input field can ever be addressed.
  localparam int unsigned Depth = (MAX_NODES > 1024) ? 1024 : MAX_NODES;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned EntW  = GEN_W + AW;

  kufb_state_e state_q, state_d;

  logic [NODE_W-1:0]   a_q, a_d;
  logic [NODE_W-1:0]   b_q, b_d;
  logic [WEIGHT_W-1:0] w_q, w_d;
  logic                item_q, item_d;
  logic                side_q, side_d;
  logic [AW-1:0]       cur_q, cur_d;
  logic [AW-1:0]       node_q, node_d;
  logic [AW-1:0]       root_q, root_d;
  logic [AW-1:0]       root_a_q, root_a_d;
  logic [AW-1:0]       sweep_q, sweep_d;
  logic [GEN_W-1:0]    gen_q, gen_d;

  logic [TOTAL_W-1:0]  weight_q, weight_d;
  logic [NODE_W-1:0]   count_q, count_d;
  logic                done_q, done_d;
  logic                joined_q, joined_d;
  logic [NODE_W-1:0]   node_count_q;

  logic                out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;

  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [EntW-1:0]     mem_wdata;
  logic [AW-1:0]       mem_raddr;
  logic [EntW-1:0]     mem_rdata;

  logic                in_beat;
  logic [AW-1:0]       link_eff;
  logic                a_ok, b_ok;
  logic [NODE_W-1:0]   count_inc;
  logic [GEN_W-1:0]    gen_inc;

  // Forest RAM: each entry holds a generation tag and a parent link.
  kufb_ram #(
    .Width (EntW),
    .Depth (Depth)
  ) u_forest (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // An entry from an older generation reads as a node that is its own root.
  assign link_eff = (mem_rdata[AW +: GEN_W] == gen_q) ? mem_rdata[AW-1:0] : cur_q;

  assign in_beat   = s_axis_tvalid_i && s_axis_tready_o;
  assign a_ok      = {1'b0, a_q} < (NODE_W + 1)'(Depth);
  assign b_ok      = {1'b0, b_q} < (NODE_W + 1)'(Depth);
  assign count_inc = count_q + NODE_W'(1);
  assign gen_inc   = gen_q + GEN_W'(1);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // Sequencer: next state, datapath updates and RAM control.
  always_comb begin
    state_d     = state_q;
    a_d         = a_q;
    b_d         = b_q;
    w_d         = w_q;
    item_d      = item_q;
    side_d      = side_q;
    cur_d       = cur_q;
    node_d      = node_q;
    root_d      = root_q;
    root_a_d    = root_a_q;
    sweep_d     = sweep_q;
    gen_d       = gen_q;
    weight_d    = weight_q;
    count_d     = count_q;
    done_d      = done_q;
    joined_d    = joined_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_data_d  = out_data_q;
    mem_we      = 1'b0;
    mem_waddr   = cur_q;
    mem_wdata   = {gen_q, root_q};
    mem_raddr   = cur_q;

    unique case (state_q)
      ST_SWEEP: begin
        // Rewrite every entry as a self-rooted node of generation zero.
        mem_we    = 1'b1;
        mem_waddr = sweep_q;
        mem_wdata = {GEN_W'(0), sweep_q};
        sweep_d   = sweep_q + AW'(1);
        if (sweep_q == AW'(Depth - 1)) begin
          sweep_d = '0;
          state_d = item_q ? ST_BEGIN : ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_beat) begin
          a_d    = s_axis_tdata_i[9:0];
          b_d    = s_axis_tdata_i[19:10];
          w_d    = s_axis_tdata_i[35:20];
          item_d = 1'b1;
          state_d = ST_BEGIN;
          // A first edge starts a new forest and clears the totals.
          if (s_axis_tuser_i[0]) begin
            weight_d = '0;
            count_d  = '0;
            done_d   = 1'b0;
            gen_d    = gen_inc;
            if (gen_inc == '0) begin
              state_d = ST_SWEEP;
            end
          end
        end
      end

      ST_BEGIN: begin
        joined_d = 1'b0;
        if (done_q || !a_ok || !b_ok) begin
          state_d = ST_RESULT;
        end else begin
          side_d  = 1'b0;
          node_d  = AW'(a_q);
          cur_d   = AW'(a_q);
          state_d = ST_FIND_RD;
        end
      end

      ST_FIND_RD: begin
        mem_raddr = cur_q;
        state_d   = ST_FIND_CHK;
      end

      ST_FIND_CHK: begin
        // Walk parent links until a node points at itself.
        if (link_eff == cur_q) begin
          root_d  = cur_q;
          cur_d   = node_q;
          state_d = ST_COMP_RD;
        end else begin
          cur_d   = link_eff;
          state_d = ST_FIND_RD;
        end
      end

      ST_COMP_RD: begin
        // Second pass over the walked path, pointing each node at the root.
        mem_raddr = cur_q;
        if (cur_q == root_q) begin
          if (!side_q) begin
            root_a_d = root_q;
            side_d   = 1'b1;
            node_d   = AW'(b_q);
            cur_d    = AW'(b_q);
            state_d  = ST_FIND_RD;
          end else begin
            state_d  = ST_LINK;
          end
        end else begin
          state_d = ST_COMP_WR;
        end
      end

      ST_COMP_WR: begin
        mem_we    = 1'b1;
        mem_waddr = cur_q;
        mem_wdata = {gen_q, root_q};
        cur_d     = link_eff;
        state_d   = ST_COMP_RD;
      end

      ST_LINK: begin
        // Separate trees: hang the first root under the second.
        if (root_a_q != root_q) begin
          mem_we    = 1'b1;
          mem_waddr = root_a_q;
          mem_wdata = {gen_q, root_q};
          weight_d  = TOTAL_W'(weight_q + TOTAL_W'(w_q));
          count_d   = count_inc;
          joined_d  = 1'b1;
          if (count_inc >= node_count_q) begin
            done_d = 1'b1;
          end
        end
        state_d = ST_RESULT;
      end

      ST_RESULT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = {2'b00, done_q, count_q, weight_q, joined_q};
          item_d      = 1'b0;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_SWEEP;
      item_q       <= 1'b0;
      side_q       <= 1'b0;
      sweep_q      <= '0;
      gen_q        <= '0;
      weight_q     <= '0;
      count_q      <= '0;
      done_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      node_count_q <= NODE_W'(NODE_COUNT_RST);
    end else begin
      state_q     <= state_d;
      item_q      <= item_d;
      side_q      <= side_d;
      sweep_q     <= sweep_d;
      gen_q       <= gen_d;
      weight_q    <= weight_d;
      count_q     <= count_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        node_count_q <= cfg_data_i;
      end
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    b_q        <= b_d;
    w_q        <= w_d;
    cur_q      <= cur_d;
    node_q     <= node_d;
    root_q     <= root_d;
    root_a_q   <= root_a_d;
    joined_q   <= joined_d;
    out_data_q <= out_data_d;
  end

  // A join adds exactly one to the edge count.
  a_join_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LINK) && (root_a_q != root_q)
      |=> count_q == $past(count_inc))
    else $error("join did not advance the edge count by one");

  // The tree stays complete until a first edge is taken.
  a_done_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && !(in_beat && s_axis_tuser_i[0]) |=> done_q)
    else $error("complete flag dropped without a first edge");

  // The tree weight only moves on a link or on an accepted beat.
  a_weight_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_LINK) && !in_beat |=> $stable(weight_q))
    else $error("tree weight changed outside a link step");

endmodule

[tb/kruskal_union_find_tree_builder_tb.sv]
// ----------------------------------------------------------------------------
// kruskal_union_find_tree_builder_tb: self-checking bench for the tree builder
// Drives edge beats, tracks the union-find forest and the running tree totals
// alongside the block, and compares every result beat field by field.
// ----------------------------------------------------------------------------
module kruskal_union_find_tree_builder_tb
  import kufb_pkg::*;
();

  localparam int unsigned FOREST_SIZE    = MAX_NODES_DEF;
  localparam int unsigned PHASE_EDGES    = 250;
  localparam int unsigned SETTLE_CYCLES  = 64;
  localparam int unsigned RX_HOLD_CYCLES = 400;

  typedef struct packed {
    logic [NODE_W-1:0]   src;
    logic [NODE_W-1:0]   dst;
    logic [WEIGHT_W-1:0] weight;
    logic                first;
  } edge_beat_t;

  typedef struct packed {
    logic                joined;
    logic [TOTAL_W-1:0]  total;
    logic [NODE_W-1:0]   taken;
    logic                complete;
  } tree_status_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  // [9:0] edge_start, [19:10] edge_end, [35:20] edge_weight.
  logic [IN_DATA_W-1:0]  s_axis_tdata_i;
  // [0] first_edge.
  logic [0:0]            s_axis_tuser_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  // [0] joined, [26:1] tree_weight, [36:27] edges_taken, [37] complete.
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [NODE_W-1:0]     cfg_data_i;

  kruskal_union_find_tree_builder uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  // Shadow forest, totals and node count register.
  logic [NODE_W-1:0]  forest_parent [FOREST_SIZE];
  logic [TOTAL_W-1:0] tree_total;
  logic [NODE_W-1:0]  join_total;
  logic               tree_done;
  logic [NODE_W-1:0]  node_count_reg;

  tree_status_t status_q[$];
  int unsigned  error_count    = 0;
  int unsigned  live_edges     = 0;
  int unsigned  send_gap_pct   = 0;
  int unsigned  recv_stall_pct = 0;
  int unsigned  rx_hold_left   = 0;

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Every node becomes its own root and the totals restart.
  function automatic void clear_forest();
    int i;
    for (i = 0; i < FOREST_SIZE; i++) begin
      forest_parent[i] = NODE_W'(i);
    end
    tree_total = '0;
    join_total = '0;
    tree_done  = 1'b0;
  endfunction

  // Walk to the root, then point every node on the walked path at it.
  function automatic logic [NODE_W-1:0] find_root(input logic [NODE_W-1:0] node);
    logic [NODE_W-1:0] root;
    logic [NODE_W-1:0] next;
    root = node;
    while (forest_parent[root] != root) begin
      root = forest_parent[root];
    end
    while (node != root) begin
      next = forest_parent[node];
      forest_parent[node] = root;
      node = next;
    end
    return root;
  endfunction

  // Applies one edge to the shadow forest and returns the status it yields.
  function automatic tree_status_t grow_tree(input edge_beat_t e);
    logic [NODE_W-1:0] root_a;
    logic [NODE_W-1:0] root_b;
    tree_status_t      s;
    s.joined = 1'b0;
    if (e.first) begin
      clear_forest();
    end
    if (!tree_done) begin
      root_a = find_root(e.src);
      root_b = find_root(e.dst);
      if (root_a != root_b) begin
        forest_parent[root_a] = root_b;
        tree_total = tree_total + TOTAL_W'(e.weight);
        join_total = join_total + 1'b1;
        s.joined   = 1'b1;
        if (join_total >= node_count_reg) begin
          tree_done = 1'b1;
        end
      end
    end
    s.total    = tree_total;
    s.taken    = join_total;
    s.complete = tree_done;
    return s;
  endfunction

  // Offers one edge beat and records its expected status once it is taken.
  task automatic send_edge(input logic [NODE_W-1:0] src, input logic [NODE_W-1:0] dst,
                           input logic [WEIGHT_W-1:0] weight, input logic first);
    edge_beat_t e;
    e.src    = src;
    e.dst    = dst;
    e.weight = weight;
    e.first  = first;
    @(negedge clk_i);
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= IN_DATA_W'({weight, dst, src});
    s_axis_tuser_i  <= first;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (first || !tree_done) begin
      live_edges++;
    end
    status_q.insert(status_q.size(), grow_tree(e));
  endtask

  // Drops the edge stream and waits until every result has come back.
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (status_q.size() != 0);
  endtask

  // Writes node_count while the block has nothing in flight.
  task automatic write_node_count(input logic [NODE_W-1:0] count);
    wait_drained();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= count;
    do @(posedge clk_i); while (!cfg_ready_o);
    node_count_reg = count;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Reset leaves a clean forest, so joins work without a first edge.
  task automatic test_reset_state();
    send_edge(10'd0, 10'd1023, 16'hFFFF, 1'b0);
    send_edge(10'd1023, 10'd0, 16'h0000, 1'b0);
    send_edge(10'd5, 10'd5, 16'd7, 1'b0);
    send_edge(10'd0, 10'd5, 16'd1, 1'b0);
  endtask

  // A complete tree ignores edges, and a node_count write does not reopen it.
  task automatic test_completion_hold();
    write_node_count(10'd2);
    send_edge(10'd2, 10'd3, 16'd1, 1'b1);
    send_edge(10'd3, 10'd4, 16'hFFFF, 1'b0);
    send_edge(10'd7, 10'd8, 16'd9, 1'b0);
    write_node_count(10'd1023);
    send_edge(10'd9, 10'd10, 16'd1, 1'b0);
  endtask

  // Lowering node_count below the join count completes on the next join.
  task automatic test_lowered_count();
    send_edge(10'd1, 10'd2, 16'd10, 1'b1);
    send_edge(10'd2, 10'd3, 16'd20, 1'b0);
    send_edge(10'd3, 10'd1, 16'd30, 1'b0);
    send_edge(10'd4, 10'd5, 16'd40, 1'b0);
    write_node_count(10'd1);
    send_edge(10'd6, 10'd7, 16'd50, 1'b0);
    send_edge(10'd8, 10'd9, 16'd60, 1'b0);
  endtask

  // With node_count 1 one join finishes the tree; a first edge reopens it.
  task automatic test_single_join();
    send_edge(10'd1023, 10'd1022, 16'hFFFF, 1'b1);
    send_edge(10'd0, 10'd1, 16'd0, 1'b0);
    send_edge(10'd0, 10'd0, 16'd3, 1'b1);
    send_edge(10'd682, 10'd341, 16'h5555, 1'b0);
    send_edge(10'd341, 10'd682, 16'hAAAA, 1'b1);
  endtask

  // The result side holds off while edges keep coming, so the input stalls.
  task automatic test_output_backpressure();
    int i;
    write_node_count(10'd1023);
    wait_drained();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    rx_hold_left   = RX_HOLD_CYCLES;
    send_edge(10'd0, 10'd1, WEIGHT_W'($urandom), 1'b1);
    for (i = 0; i < 20; i++) begin
      send_edge(NODE_W'($urandom_range(63)), NODE_W'($urandom_range(63)),
                WEIGHT_W'($urandom), 1'b0);
    end
    wait_drained();
  endtask

  // One tree build: a first edge, edges mostly within the node range,
  // a few stray ones, and sometimes an early abandon or a restart.
  task automatic run_random_tree(input int unsigned budget);
    int unsigned       pick;
    int unsigned       span;
    int unsigned       cap;
    int unsigned       sent;
    int unsigned       extra;
    logic [NODE_W-1:0]   src;
    logic [NODE_W-1:0]   dst;
    logic [WEIGHT_W-1:0] weight;
    logic                first;
    pick = $urandom_range(99);
    if (pick < 4) begin
      span = 1023;
    end else if (pick < 10) begin
      span = 1;
    end else if (pick < 16) begin
      span = $urandom_range(1022, 41);
    end else begin
      span = $urandom_range(40, 2);
    end
    if ($urandom_range(3) != 0) begin
      write_node_count(NODE_W'(span));
    end else begin
      span = 32'(node_count_reg);
    end
    cap   = (span > 40) ? 200 : 4 * span + 20;
    cap   = (cap > budget) ? budget : cap;
    extra = $urandom_range(3);
    sent  = 0;
    while (sent < cap) begin
      if (sent != 0 && tree_done) begin
        if (extra == 0) break;
        extra--;
      end
      pick  = $urandom_range(99);
      first = (sent == 0) || (pick < 2);
      if (pick >= 2 && pick < 8) begin
        src = NODE_W'($urandom);
        dst = NODE_W'($urandom);
      end else begin
        src = NODE_W'($urandom_range(span));
        dst = NODE_W'($urandom_range(span));
      end
      case ($urandom_range(9))
        0: weight = '0;
        1: weight = '1;
        default: weight = WEIGHT_W'($urandom);
      endcase
      send_edge(src, dst, weight, first);
      sent++;
      if ($urandom_range(99) == 0) break;
    end
  endtask

  task automatic test_random_phase(input int unsigned gap_pct, input int unsigned stall_pct);
    int unsigned target;
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    target = live_edges + PHASE_EDGES;
    while (live_edges < target) begin
      run_random_tree(target - live_edges);
    end
  endtask

  // Result side ready, with random stalls and the occasional long hold-off.
  initial begin : result_sink
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_left != 0) begin
        rx_hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Compares each result beat with the oldest expected status.
  always @(posedge clk_i) begin : check_results
    tree_status_t got;
    tree_status_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.joined   = m_axis_tdata_o[0];
      got.total    = m_axis_tdata_o[26:1];
      got.taken    = m_axis_tdata_o[36:27];
      got.complete = m_axis_tdata_o[37];
      if (status_q.size() == 0) begin
        $error("result beat with no edge pending: tdata=%h", m_axis_tdata_o);
        error_count++;
      end else begin
        want = status_q.pop_front();
        if (got.joined !== want.joined) begin
          $error("joined: expected %0d, actual %0d", want.joined, got.joined);
          error_count++;
        end
        if (got.total !== want.total) begin
          $error("tree_weight: expected %0d, actual %0d", want.total, got.total);
          error_count++;
        end
        if (got.taken !== want.taken) begin
          $error("edges_taken: expected %0d, actual %0d", want.taken, got.taken);
          error_count++;
        end
        if (got.complete !== want.complete) begin
          $error("complete: expected %0d, actual %0d", want.complete, got.complete);
          error_count++;
        end
      end
    end
  end

  initial begin : watchdog
    #50_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : test_sequence
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = '0;
    node_count_reg  = NODE_W'(NODE_COUNT_RST);
    clear_forest();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_completion_hold();
    test_lowered_count();
    test_single_join();
    test_output_backpressure();
    test_random_phase(0, 0);
    test_random_phase(53, 0);
    test_random_phase(0, 53);
    test_random_phase(37, 37);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0 && status_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
